// ===== hdl/rbt_pkg.sv =====
// rbt_pkg: constants and tables shared by the range and bearing pipeline
// holds the cordic arctangent table and the inverse gain table
// no dependencies
package rbt_pkg;

  localparam int COORD_WIDTH_DEF   = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int GUARD_BITS        = 12;
  localparam int ANGLE_W           = 32;
  localparam int GAIN_W            = 26;
  localparam int GAIN_FRAC         = 26;
  localparam int BAM_W             = 16;
  localparam int DIST_W            = 15;
  localparam int MUL_SPLIT         = 16;

  localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] BAM_ROUND   = 32'h0000_8000;
  localparam logic [BAM_W-1:0]   BAM_HALF    = 16'h8000;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 15'h7FFF;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ANGLE_W-1:0] rbt_atan(input int idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  // inverse cordic gain in q26, nearest entry for the stage count
  function automatic logic [GAIN_W-1:0] rbt_gain(input int stages);
    logic [GAIN_W-1:0] k;
    if (stages <= 8) begin
      k = 26'd40752469;
    end else if (stages == 9) begin
      k = 26'd40752158;
    end else if (stages == 10) begin
      k = 26'd40752081;
    end else if (stages == 11) begin
      k = 26'd40752061;
    end else if (stages == 12) begin
      k = 26'd40752056;
    end else begin
      k = 26'd40752055;
    end
    return k;
  endfunction

endpackage

// ===== hdl/range_and_bearing_to_target.sv =====
// range_and_bearing_to_target: top level of the range and bearing pipeline
// instantiates rbt_prep, rbt_cordic_stage (one per rotation) and rbt_post
// depends on rbt_pkg
//
// usage
//   input channel (in_valid/in_ready) carries one pose beat: target and own
//   position in signed millimetres and own heading as a 16-bit binary angle
//   output channel (out_valid/out_ready) returns one beat per input beat:
//   euclidean distance in millimetres and the absolute relative bearing,
//   0..32768 where 32768 is 180 degrees
//   the pipeline registers, in order, are:
//   one difference stage, one register per cordic rotation, a split gain
//   multiply stage and a final round/saturate/fold stage
//   throughput is one beat per cycle unless out_ready stalls; every stage holds its own valid bit
//   reset clears all valid bits, the datapath registers keep stale values
//   a stall on out_ready holds the output beat; stages behind it keep
//   filling until they hit a full stage, so bubbles are squeezed out and
//   in_ready stays high while any stage still has room
module range_and_bearing_to_target import rbt_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] own_x,
  input  logic signed [COORD_WIDTH-1:0] own_y,
  input  logic        [BAM_W-1:0]       own_heading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [DIST_W-1:0]      distance,
  output logic        [BAM_W-1:0]       bearing_abs
);

  // rotation count capped at the table length
  localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  // difference plus guard bits, cordic growth and sign
  localparam int XW  = COORD_WIDTH + GUARD_BITS + 3;

  // pipeline taps: index 0 is the prep output, index NST the last rotation
  logic                      v   [0:NST];
  logic                      rdy [0:NST];
  logic signed [XW-1:0]      sx  [0:NST];
  logic signed [XW-1:0]      sy  [0:NST];
  logic        [ANGLE_W-1:0] sz  [0:NST];
  logic        [BAM_W-1:0]   sh  [0:NST];
  logic                      sz0 [0:NST];

  rbt_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .target_x    (target_x),
    .target_y    (target_y),
    .own_x       (own_x),
    .own_y       (own_y),
    .own_heading (own_heading),
    .out_valid   (v[0]),
    .out_ready   (rdy[0]),
    .x           (sx[0]),
    .y           (sy[0]),
    .z           (sz[0]),
    .heading     (sh[0]),
    .zero        (sz0[0])
  );

  // one register stage per micro-rotation
  for (genvar i = 0; i < NST; i++) begin : g_rot
    rbt_cordic_stage #(
      .IDX (i),
      .XW  (XW)
    ) u_rot (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (v[i]),
      .in_ready   (rdy[i]),
      .x_in       (sx[i]),
      .y_in       (sy[i]),
      .z_in       (sz[i]),
      .heading_in (sh[i]),
      .zero_in    (sz0[i]),
      .out_valid  (v[i+1]),
      .out_ready  (rdy[i+1]),
      .x          (sx[i+1]),
      .y          (sy[i+1]),
      .z          (sz[i+1]),
      .heading    (sh[i+1]),
      .zero       (sz0[i+1])
    );
  end

  // gain correction and bearing fold; y of the last rotation is not needed
  rbt_post #(
    .XW     (XW),
    .STAGES (NST)
  ) u_post (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v[NST]),
    .in_ready    (rdy[NST]),
    .x_in        (sx[NST]),
    .z_in        (sz[NST]),
    .heading_in  (sh[NST]),
    .zero_in     (sz0[NST]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance),
    .bearing_abs (bearing_abs)
  );

  // folded bearing never passes half a turn
  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing_abs <= BAM_HALF))
    else $error("bearing beyond half a turn");

  // an accepting receiver leaves room all the way back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // reset empties the whole pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output beat right after reset");

  // an empty pipeline always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v[0] && !out_valid) |-> in_ready)
    else $error("empty pipeline refuses input");

endmodule

// ===== hdl/rbt_prep.sv =====
// rbt_prep: position difference and half-plane fold ahead of the cordic
// one register stage with valid/ready
// depends on rbt_pkg
module rbt_prep import rbt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int XW          = COORD_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] own_x,
  input  logic signed [COORD_WIDTH-1:0] own_y,
  input  logic        [BAM_W-1:0]       own_heading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          x,
  output logic signed [XW-1:0]          y,
  output logic        [ANGLE_W-1:0]     z,
  output logic        [BAM_W-1:0]       heading,
  output logic                          zero
);

  logic signed [COORD_WIDTH:0] dx, dy;
  logic signed [XW-1:0]        xs, ys;

  assign dx = {target_x[COORD_WIDTH-1], target_x} - {own_x[COORD_WIDTH-1], own_x};
  assign dy = {target_y[COORD_WIDTH-1], target_y} - {own_y[COORD_WIDTH-1], own_y};
  assign xs = XW'(dx) <<< GUARD_BITS;
  assign ys = XW'(dy) <<< GUARD_BITS;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      // left half plane: rotate by half a turn first
      if (dx < 0) begin
        x <= -xs;
        y <= -ys;
        z <= HALF_TURN;
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
      heading <= own_heading;
      zero    <= (dx == 0) && (dy == 0);
    end
  end

endmodule

// ===== hdl/rbt_cordic_stage.sv =====
// rbt_cordic_stage: one vectoring micro-rotation with its pipeline register
// depends on rbt_pkg for the arctangent table
module rbt_cordic_stage import rbt_pkg::*; #(
  parameter int IDX = 0,
  parameter int XW  = COORD_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [XW-1:0]      x_in,
  input  logic signed [XW-1:0]      y_in,
  input  logic        [ANGLE_W-1:0] z_in,
  input  logic        [BAM_W-1:0]   heading_in,
  input  logic                      zero_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [XW-1:0]      x,
  output logic signed [XW-1:0]      y,
  output logic        [ANGLE_W-1:0] z,
  output logic        [BAM_W-1:0]   heading,
  output logic                      zero
);

  localparam logic [ANGLE_W-1:0] ATAN = rbt_atan(IDX);

  logic signed [XW-1:0] xsh, ysh;

  assign xsh = x_in >>> IDX;
  assign ysh = y_in >>> IDX;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      if (!y_in[XW-1]) begin
        x <= x_in + ysh;
        y <= y_in - xsh;
        z <= z_in + ATAN;
      end else begin
        x <= x_in - ysh;
        y <= y_in + xsh;
        z <= z_in - ATAN;
      end
      heading <= heading_in;
      zero    <= zero_in;
    end
  end

endmodule

// ===== hdl/rbt_post.sv =====
// rbt_post: gain correction of the magnitude and bearing fold
// two register stages: split multiply and relative bearing, then sum, round, saturate and fold
// depends on rbt_pkg
module rbt_post import rbt_pkg::*; #(
  parameter int XW     = COORD_WIDTH_DEF + GUARD_BITS + 3,
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [XW-1:0]      x_in,
  input  logic        [ANGLE_W-1:0] z_in,
  input  logic        [BAM_W-1:0]   heading_in,
  input  logic                      zero_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [DIST_W-1:0]  distance,
  output logic        [BAM_W-1:0]   bearing_abs
);

  localparam logic [GAIN_W-1:0] GAIN = rbt_gain(STAGES);
  localparam int UW    = XW - 1;
  localparam int HW    = UW - MUL_SPLIT;
  localparam int LOW_W = MUL_SPLIT + GAIN_W;
  localparam int HIW   = HW + GAIN_W;
  localparam int SW    = XW + GAIN_W;
  localparam int SHIFT = GUARD_BITS + GAIN_FRAC;
  localparam int QW    = SW - SHIFT;

  // stage a
  logic              a_valid, a_ready;
  logic [LOW_W-1:0]  p_lo;
  logic [HIW-1:0]    p_hi;
  logic [BAM_W-1:0]  rel;

  logic [UW-1:0]      xu;
  logic [ANGLE_W-1:0] z_rnd;
  logic [BAM_W-1:0]   ang;

  assign xu    = x_in[XW-1] ? '0 : x_in[UW-1:0];
  assign z_rnd = z_in + BAM_ROUND;
  assign ang   = zero_in ? '0 : z_rnd[ANGLE_W-1:ANGLE_W-BAM_W];

  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_lo <= LOW_W'(xu[MUL_SPLIT-1:0]) * LOW_W'(GAIN);
      p_hi <= HIW'(xu[UW-1:MUL_SPLIT]) * HIW'(GAIN);
      rel  <= ang - heading_in;
    end
  end

  // stage b
  logic [SW-1:0] sum;
  logic [QW-1:0] q;
  logic [63:0]   q64;

  assign sum = (SW'(p_hi) << MUL_SPLIT) + SW'(p_lo) + (SW'(1) << (SHIFT - 1));
  assign q   = sum[SW-1:SHIFT];
  assign q64 = 64'(q);

  assign a_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      distance    <= (q64 > 64'(DIST_MAX)) ? DIST_MAX : q64[DIST_W-1:0];
      // negative half folds over; half a turn maps onto itself
      bearing_abs <= rel[BAM_W-1] ? (BAM_W'(0) - rel) : rel;
    end
  end

endmodule
